// ===== rtl/bit_stream_packer_unpacker_defines.svh =====
// Assertion macros for the bit stream packer and unpacker.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef BIT_STREAM_PACKER_UNPACKER_DEFINES_SVH
`define BIT_STREAM_PACKER_UNPACKER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication check
`define BSP_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsp: same-cycle check failed");
// Next-cycle implication check
`define BSP_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bsp: next-cycle check failed");
`else
`define BSP_ASSERT_IMP(name, clk, rst, ante, cons)
`define BSP_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/bsp_pkg.sv =====
// Shared constants, codes and types of the bit stream packer and unpacker.
// No dependencies; imported by every module of the block.
package bsp_pkg;

   localparam int STORE_BYTES = 1024;
   localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int CURSOR_W    = $clog2(STORE_BYTES * 8 + 1);
   localparam int BYTE_W      = CURSOR_W - 3;
   localparam int VALUE_W     = 64;
   localparam int COUNT_W     = 7;
   localparam int LEVEL_W     = 14;
   localparam int MAX_BITS    = 64;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_READ   = 2'd1,
      OP_REWIND = 2'd2,
      OP_CLEAR  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WR_STEP,
      ST_WR_MERGE,
      ST_RD_FIRST,
      ST_RD_DATA,
      ST_DONE
   } state_type;

   // Controls for the shared byte-lane unit
   typedef struct packed {
      logic [COUNT_W-1:0] remaining;
      logic [2:0]         bit_idx;
      logic               merge;
   } lane_ctl_type;

   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        wdata;
   } ram_req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] read_value;
      status_type         status;
      logic [LEVEL_W-1:0] bits_available;
      logic [LEVEL_W-1:0] bits_written;
   } result_type;

endpackage

// ===== rtl/bsp_byte_ram.sv =====
// Byte-wide single-port store with registered read data.
// Depends on bsp_pkg for depth and address width.
module bsp_byte_ram (
   input  logic                clock,
   input  bsp_pkg::ram_req_type req,
   output logic [7:0]          rdata
);
   import bsp_pkg::*;

   logic [7:0] mem [STORE_BYTES];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.addr] <= req.wdata;
      end
      if (req.rd_en) begin
         rdata_ff <= mem[req.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/bsp_lane_unit.sv =====
// Shared byte-lane unit: picks the next bits of a word for one byte of the store,
// places or merges them, and extracts read bits into the accumulator. Uses bsp_pkg.
module bsp_lane_unit (
   input  bsp_pkg::lane_ctl_type ctl,
   input  logic [63:0]           value,
   input  logic [7:0]            rdata,
   input  logic [63:0]           acc,
   output logic [3:0]            n_bits,
   output logic [7:0]            wr_byte,
   output logic [63:0]           acc_next
);
   import bsp_pkg::*;

   logic [3:0]         room;
   logic [3:0]         gap;
   logic [7:0]         mask;
   logic [COUNT_W-1:0] shamt;
   logic [7:0]         chunk;
   logic [7:0]         placed;
   logic [7:0]         rd_bits;

   always_comb begin
      room    = 4'd8 - {1'b0, ctl.bit_idx};
      n_bits  = (ctl.remaining < {3'b000, room}) ? ctl.remaining[3:0] : room;
      mask    = 8'((9'd1 << n_bits) - 9'd1);
      // bits of the word still to go sit at [remaining-1 : 0]
      shamt   = ctl.remaining - {3'b000, n_bits};
      chunk   = 8'(value >> shamt) & mask;
      gap     = room - n_bits;
      placed  = chunk << gap;
      wr_byte = ctl.merge ? (rdata | placed) : placed;
      rd_bits = (rdata >> gap) & mask;
      acc_next = (acc << n_bits) | {56'd0, rd_bits};
   end

endmodule

// ===== rtl/bsp_ctrl.sv =====
// Sequencer of the bit stream block: cursor, stored length and byte steps, one at a time
// through the shared lane unit and the byte store. Uses bsp_pkg, bsp_lane_unit, bsp_byte_ram.
`include "bit_stream_packer_unpacker_defines.svh"
module bsp_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_opcode,
   input  logic [bsp_pkg::VALUE_W-1:0] req_write_value,
   input  logic [bsp_pkg::COUNT_W-1:0] req_bit_count,
   input  logic                        out_free,
   output logic                        done_valid,
   output bsp_pkg::result_type         done_res
);
   import bsp_pkg::*;

   state_type           state_ff, state_in;
   logic [CURSOR_W-1:0] cursor_ff, cursor_in;
   logic [BYTE_W-1:0]   length_ff, length_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [VALUE_W-1:0]  acc_ff, acc_in;
   status_type          status_ff, status_in;
   logic [BYTE_W-1:0]   ptr_ff, ptr_in;

   logic [BYTE_W-1:0]   byte_idx;
   logic [2:0]          bit_idx;
   logic [CURSOR_W-1:0] total_bits;
   logic [CURSOR_W-1:0] avail;
   logic                accept;
   logic                store_end;
   logic [COUNT_W-1:0]  count_sat;

   lane_ctl_type        lane_ctl;
   logic [3:0]          n_bits;
   logic [7:0]          lane_byte;
   logic [VALUE_W-1:0]  acc_next;
   ram_req_type         ram_req;
   logic [7:0]          ram_rdata;

   bsp_lane_unit u_lane (
      .ctl      (lane_ctl),
      .value    (value_ff),
      .rdata    (ram_rdata),
      .acc      (acc_ff),
      .n_bits   (n_bits),
      .wr_byte  (lane_byte),
      .acc_next (acc_next)
   );

   bsp_byte_ram u_ram (
      .clock (clock),
      .req   (ram_req),
      .rdata (ram_rdata)
   );

   assign byte_idx   = cursor_ff[CURSOR_W-1:3];
   assign bit_idx    = cursor_ff[2:0];
   assign total_bits = {length_ff, 3'b000};
   assign avail      = (total_bits > cursor_ff) ? (total_bits - cursor_ff) : '0;
   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign store_end  = (byte_idx >= BYTE_W'(STORE_BYTES));
   assign count_sat  = (req_bit_count > COUNT_W'(MAX_BITS)) ? COUNT_W'(MAX_BITS) : req_bit_count;
   // merge with the fetched byte only in ST_WR_MERGE, the step after a partly filled byte is fetched
   assign lane_ctl   = '{remaining: rem_ff, bit_idx: bit_idx,
                         merge: (state_ff == ST_WR_MERGE)};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (opcode_type'(req_opcode))
                  OP_WRITE: state_in = ST_WR_STEP;
                  OP_READ:  state_in = ST_RD_FIRST;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_WR_STEP: begin
            if (rem_ff == '0) begin
               state_in = ST_DONE;
            end else if (bit_idx != 3'd0) begin
               state_in = ST_WR_MERGE;
            end else if (store_end) begin
               state_in = ST_DONE;
            end
         end
         ST_WR_MERGE: state_in = ST_WR_STEP;
         ST_RD_FIRST: begin
            if (rem_ff == '0 || byte_idx >= length_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_RD_DATA;
            end
         end
         ST_RD_DATA: begin
            if (rem_ff == {3'b000, n_bits} || ptr_ff >= length_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cursor_in      = cursor_ff;
      length_in      = length_ff;
      rem_in         = rem_ff;
      value_in       = value_ff;
      acc_in         = acc_ff;
      status_in      = status_ff;
      ptr_in         = ptr_ff;
      ram_req        = '{wr_en: 1'b0, rd_en: 1'b0, addr: byte_idx[ADDR_W-1:0], wdata: lane_byte};
      done_valid     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               value_in  = req_write_value;
               rem_in    = count_sat;
               acc_in    = '0;
               status_in = STAT_OK;
               case (opcode_type'(req_opcode))
                  OP_REWIND: cursor_in = '0;
                  OP_CLEAR: begin
                     cursor_in = '0;
                     length_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_WR_STEP: begin
            if (rem_ff != '0) begin
               if (bit_idx != 3'd0) begin
                  // partly filled byte: fetch it for a merge
                  ram_req.rd_en = 1'b1;
               end else if (store_end) begin
                  status_in = STAT_FULL;
               end else begin
                  // fresh byte: overwrite, which clears the unused low bits
                  ram_req.wr_en = 1'b1;
                  cursor_in     = cursor_ff + CURSOR_W'(n_bits);
                  rem_in        = rem_ff - COUNT_W'(n_bits);
                  if (length_ff <= byte_idx) begin
                     length_in = byte_idx + BYTE_W'(1);
                  end
               end
            end
         end
         ST_WR_MERGE: begin
            ram_req.wr_en  = 1'b1;
            cursor_in      = cursor_ff + CURSOR_W'(n_bits);
            rem_in         = rem_ff - COUNT_W'(n_bits);
         end
         ST_RD_FIRST: begin
            if (rem_ff != '0) begin
               if (byte_idx >= length_ff) begin
                  status_in = STAT_RANGE;
               end else begin
                  ram_req.rd_en = 1'b1;
                  ptr_in        = byte_idx + BYTE_W'(1);
               end
            end
         end
         ST_RD_DATA: begin
            // consume the byte that arrived; prefetch the next one
            cursor_in = cursor_ff + CURSOR_W'(n_bits);
            rem_in    = rem_ff - COUNT_W'(n_bits);
            acc_in    = acc_next;
            if (rem_ff != {3'b000, n_bits}) begin
               if (ptr_ff >= length_ff) begin
                  status_in = STAT_RANGE;
                  acc_in    = '0;
               end else begin
                  ram_req.rd_en = 1'b1;
                  ram_req.addr  = ptr_ff[ADDR_W-1:0];
                  ptr_in        = ptr_ff + BYTE_W'(1);
               end
            end
         end
         ST_DONE: done_valid = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      done_res.read_value     = acc_ff;
      done_res.status         = status_ff;
      done_res.bits_available = LEVEL_W'(avail);
      done_res.bits_written   = LEVEL_W'(cursor_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cursor_ff <= '0;
         length_ff <= '0;
      end else begin
         state_ff  <= state_in;
         cursor_ff <= cursor_in;
         length_ff <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      value_ff  <= value_in;
      acc_ff    <= acc_in;
      status_ff <= status_in;
      ptr_ff    <= ptr_in;
   end

   `BSP_ASSERT_IMP(a_cursor_covered, clock, reset, 1'b1, cursor_ff <= total_bits)
   `BSP_ASSERT_IMP(a_length_cap, clock, reset, 1'b1, length_ff <= BYTE_W'(STORE_BYTES))
   `BSP_ASSERT_NXT(a_merge_returns, clock, reset, state_ff == ST_WR_MERGE, state_ff == ST_WR_STEP)
   `BSP_ASSERT_IMP(a_single_port, clock, reset, ram_req.wr_en, !ram_req.rd_en)

endmodule

// ===== rtl/bit_stream_packer_unpacker.sv =====
// MSB-first bit stream packer and unpacker: one byte store, one shared bit cursor.
// An item is taken only while the sequencer is idle and is worked one store byte at a
// time through the single-port byte memory: rewind and length reset go straight to the
// result, a write overwrites a fresh byte and fetches then merges a partly filled one,
// and a read fetches its first byte, then consumes each byte while prefetching the next;
// a 64-bit access can span nine bytes. The result sits in an output register, so the
// next word is accepted while it waits to be taken. Depends on bsp_pkg and bsp_ctrl.
module bit_stream_packer_unpacker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_opcode,
   input  logic [bsp_pkg::VALUE_W-1:0] req_write_value,
   input  logic [bsp_pkg::COUNT_W-1:0] req_bit_count,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [bsp_pkg::VALUE_W-1:0] rsp_read_value,
   output logic [1:0]                  rsp_status,
   output logic [bsp_pkg::LEVEL_W-1:0] rsp_bits_available,
   output logic [bsp_pkg::LEVEL_W-1:0] rsp_bits_written
);
   import bsp_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type result_ff, result_in;
   logic       out_free;
   logic       done_valid;
   result_type done_res;

   bsp_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_write_value (req_write_value),
      .req_bit_count   (req_bit_count),
      .out_free        (out_free),
      .done_valid      (done_valid),
      .done_res        (done_res)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      // load a finished word once the output register is free
      if (done_valid && out_free) begin
         rsp_valid_in = 1'b1;
         result_in    = done_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_value     = result_ff.read_value;
   assign rsp_status         = result_ff.status;
   assign rsp_bits_available = result_ff.bits_available;
   assign rsp_bits_written   = result_ff.bits_written;

endmodule
